// ===== rtl/core/stm_pkg.sv =====
// ----------------------------------------------------------------------------
// stm_pkg
// Shared constants of the sequence trajectory matcher.
// ----------------------------------------------------------------------------
package stm_pkg;

	localparam logic [2:0] CFG_FRAME_COUNT   = 3'd0;
	localparam logic [2:0] CFG_MATCH_LEN     = 3'd1;
	localparam logic [2:0] CFG_MIN_SHIFT     = 3'd2;
	localparam logic [2:0] CFG_MAX_SHIFT     = 3'd3;
	localparam logic [2:0] CFG_REJECT_WINDOW = 3'd4;

	localparam logic [16:0] RATIO_ONE = 17'h10000;

endpackage

// ===== rtl/core/sequence_trajectory_matcher.sv =====
// ----------------------------------------------------------------------------
// sequence_trajectory_matcher
// Sequence matching over a square frame difference matrix.
// ----------------------------------------------------------------------------
// A load (opcode 0) writes one matrix cell and finishes at once; no result.
// A query (opcode 1) holds busy high while one adder walks every start column,
// every speed and every trajectory cell, one matrix read per cycle. With
// S = frames - m starts and V = max(max_shift, min_shift) - min_shift + 1
// speeds, a query walks S*V trajectories of m + 1 cells, paced by the single
// read port of the difference store and the serial speed divider. An invalid
// query answers on the next cycle. Each result appears for one cycle with
// done high and must be captured then. Configuration is accepted every cycle
// (cfg_ready is always high) and should only be written while busy is low.
// ----------------------------------------------------------------------------
module sequence_trajectory_matcher
	import stm_pkg::*;
#(
	parameter int MAX_FRAMES    = 256,
	parameter int MAX_MATCH_LEN = 64,
	parameter int DIFF_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [7:0]  row_index,
	input  logic [7:0]  col_index,
	input  logic [15:0] diff_value,
	input  logic [7:0]  query_frame,
	output logic        done,
	output logic [7:0]  match_frame,
	output logic [16:0] score_ratio,
	output logic        invalid,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int FW   = $clog2(MAX_FRAMES);
	localparam int FCW  = $clog2(MAX_FRAMES + 1);
	localparam int MW   = $clog2(MAX_MATCH_LEN + 1);
	localparam int MTOP = MAX_MATCH_LEN & ~1;
	localparam int SW   = DIFF_BITS + $clog2(MAX_MATCH_LEN + 2);
	localparam int AW   = 2 * FW;
	localparam int CLW  = ((FW > 8) ? FW : 8) + 2;

	typedef enum logic [3:0] {
		S_IDLE, S_DIVV, S_WALK, S_TAIL, S_KEEP, S_SCAN1, S_SCAN1T,
		S_WIN, S_SCAN2, S_SCAN2T, S_FIN, S_DIVR
	} state_t;

	state_t state_q;

	logic [8:0] fc_q;
	logic [6:0] ml_q;
	logic [7:0] mins_q;
	logic [7:0] maxs_q;
	logic [8:0] rw_q;

	logic [FCW-1:0] f_q;
	logic [MW-1:0]  m_q;
	logic [MW-1:0]  half_q;
	logic [FCW-1:0] starts_q;
	logic [FW-1:0]  row0_q;
	logic [7:0]     vmax_q;
	logic [7:0]     v_q;
	logic [FW-1:0]  s_q;
	logic [MW-1:0]  i_q;
	logic [8:0]     off_q;
	logic [MW-1:0]  acc_q;
	logic [7:0]     dsh_q;
	logic [MW-1:0]  drem_q;
	logic [3:0]     dcnt_q;
	logic [SW-1:0]  sum_q;
	logic [SW-1:0]  low_q;
	logic           pend_q;
	logic [FW-1:0]  k_q;
	logic [FW-1:0]  rk_q;
	logic [FW-1:0]  best_idx_q;
	logic [SW-1:0]  best_val_q;
	logic [SW-1:0]  sec_val_q;
	logic           found_q;
	logic [FCW-1:0] lo_q;
	logic [FCW-1:0] hi_q;
	logic [SW:0]    rem_q;
	logic [15:0]    quo_q;

	logic        done_q;
	logic [7:0]  match_frame_q;
	logic [16:0] score_ratio_q;
	logic        invalid_q;

	logic [FCW-1:0] f_c;
	logic [7:0]     ml_rnd;
	logic [MW-1:0]  m_c;
	logic [MW-1:0]  half_c;
	logic           bad_c;
	logic           accept;
	logic [FW-1:0]  row_c;
	logic [FW-1:0]  col_c;
	logic [CLW-1:0] col_sum;
	logic [MW:0]    trial_v;
	logic [MW:0]    nacc;
	logic [SW-1:0]  newlow;
	logic [SW:0]    trial_r;
	logic           excl;
	logic [7:0]     hr;
	logic [31:0]    lo_w;
	logic [31:0]    hi_w;

	logic                 dwe;
	logic [AW-1:0]        dwaddr;
	logic [DIFF_BITS-1:0] dwdata;
	logic [AW-1:0]        draddr;
	logic [DIFF_BITS-1:0] drdata;
	logic                 swe;
	logic [SW-1:0]        srdata;

	assign busy        = (state_q != S_IDLE);
	assign accept      = start && !busy;
	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign match_frame = match_frame_q;
	assign score_ratio = score_ratio_q;
	assign invalid     = invalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= 9'd256;
			ml_q   <= 7'd10;
			mins_q <= 8'd8;
			maxs_q <= 8'd12;
			rw_q   <= 9'd20;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_COUNT:   fc_q   <= cfg_data;
				CFG_MATCH_LEN:     ml_q   <= cfg_data[6:0];
				CFG_MIN_SHIFT:     mins_q <= cfg_data[7:0];
				CFG_MAX_SHIFT:     maxs_q <= cfg_data[7:0];
				CFG_REJECT_WINDOW: rw_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (fc_q < 9'd2) begin
			f_c = FCW'(2);
		end else if (32'(fc_q) > MAX_FRAMES) begin
			f_c = FCW'(MAX_FRAMES);
		end else begin
			f_c = FCW'(fc_q);
		end
		ml_rnd = {1'b0, ml_q} + 8'(ml_q[0]);
		if (ml_rnd < 8'd2) begin
			m_c = MW'(2);
		end else if (32'(ml_rnd) > MTOP) begin
			m_c = MW'(MTOP);
		end else begin
			m_c = MW'(ml_rnd);
		end
		half_c = m_c >> 1;
		bad_c  = (32'(f_c) < 32'(m_c) + 32'd2)
			|| (32'(query_frame) < 32'(half_c) + 32'd1)
			|| (32'(query_frame) > 32'(f_c) - 32'(half_c) - 32'd1);
	end

	always_comb begin
		row_c   = FW'(32'(row0_q) + 32'(i_q));
		col_sum = CLW'(s_q) + CLW'(off_q);
		if (col_sum > CLW'(f_q) - CLW'(1)) begin
			col_c = FW'(f_q - FCW'(1));
		end else begin
			col_c = FW'(col_sum);
		end
		trial_v = {drem_q, dsh_q[7]};
		nacc    = {1'b0, acc_q} + {1'b0, drem_q};
		newlow  = ((v_q == mins_q) || (sum_q < low_q)) ? sum_q : low_q;
		trial_r = rem_q << 1;
		excl    = (32'(rk_q) >= 32'(lo_q)) && (32'(rk_q) < 32'(hi_q));
		hr      = rw_q[8:1];
		lo_w    = (32'(best_idx_q) > 32'(hr)) ? 32'(best_idx_q) - 32'(hr) : 32'd0;
		hi_w    = 32'(best_idx_q) + 32'(hr);
		if (hi_w > 32'(starts_q)) begin
			hi_w = 32'(starts_q);
		end
		if (hr == 8'd0) begin
			hi_w = lo_w;
		end
	end

	assign dwe    = accept && !opcode && (32'(row_index) < MAX_FRAMES)
		&& (32'(col_index) < MAX_FRAMES);
	assign dwaddr = {FW'(row_index), FW'(col_index)};
	assign dwdata = DIFF_BITS'(diff_value);
	assign draddr = {row_c, col_c};
	assign swe    = (state_q == S_KEEP) && (v_q == vmax_q);

	stm_ram #(.WIDTH(DIFF_BITS), .DEPTH(MAX_FRAMES * MAX_FRAMES)) u_diff_ram (
		.clk   (clk),
		.we    (dwe),
		.waddr (dwaddr),
		.wdata (dwdata),
		.raddr (draddr),
		.rdata (drdata)
	);

	stm_ram #(.WIDTH(SW), .DEPTH(MAX_FRAMES)) u_score_ram (
		.clk   (clk),
		.we    (swe),
		.waddr (s_q),
		.wdata (newlow),
		.raddr (k_q),
		.rdata (srdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			done_q        <= 1'b0;
			match_frame_q <= '0;
			score_ratio_q <= '0;
			invalid_q     <= 1'b0;
			pend_q        <= 1'b0;
			dcnt_q        <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && opcode) begin
						if (bad_c) begin
							done_q        <= 1'b1;
							invalid_q     <= 1'b1;
							match_frame_q <= '0;
							score_ratio_q <= '0;
						end else begin
							f_q      <= f_c;
							m_q      <= m_c;
							half_q   <= half_c;
							starts_q <= f_c - FCW'(m_c);
							row0_q   <= FW'(32'(query_frame) - 32'(half_c) - 32'd1);
							vmax_q   <= (maxs_q < mins_q) ? mins_q : maxs_q;
							v_q      <= mins_q;
							dsh_q    <= mins_q;
							s_q      <= '0;
							drem_q   <= '0;
							dcnt_q   <= '0;
							state_q  <= S_DIVV;
						end
					end
				end
				S_DIVV: begin
					if (trial_v >= {1'b0, m_q}) begin
						drem_q <= MW'(trial_v - {1'b0, m_q});
						dsh_q  <= {dsh_q[6:0], 1'b1};
					end else begin
						drem_q <= MW'(trial_v);
						dsh_q  <= {dsh_q[6:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 4'd1;
					if (dcnt_q == 4'd7) begin
						i_q     <= '0;
						off_q   <= '0;
						acc_q   <= '0;
						sum_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (pend_q) begin
						sum_q <= sum_q + SW'(drdata);
					end
					pend_q <= 1'b1;
					if (nacc >= {1'b0, m_q}) begin
						acc_q <= MW'(nacc - {1'b0, m_q});
						off_q <= off_q + 9'(dsh_q) + 9'd1;
					end else begin
						acc_q <= MW'(nacc);
						off_q <= off_q + 9'(dsh_q);
					end
					i_q <= i_q + MW'(1);
					if (i_q == m_q) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					sum_q   <= sum_q + SW'(drdata);
					pend_q  <= 1'b0;
					state_q <= S_KEEP;
				end
				S_KEEP: begin
					low_q  <= newlow;
					drem_q <= '0;
					dcnt_q <= '0;
					if (v_q == vmax_q) begin
						if (32'(s_q) == 32'(starts_q) - 32'd1) begin
							k_q     <= '0;
							pend_q  <= 1'b0;
							state_q <= S_SCAN1;
						end else begin
							s_q     <= s_q + FW'(1);
							v_q     <= mins_q;
							dsh_q   <= mins_q;
							state_q <= S_DIVV;
						end
					end else begin
						v_q     <= v_q + 8'd1;
						dsh_q   <= v_q + 8'd1;
						state_q <= S_DIVV;
					end
				end
				S_SCAN1, S_SCAN1T: begin
					if (pend_q && ((rk_q == '0) || (srdata < best_val_q))) begin
						best_idx_q <= rk_q;
						best_val_q <= srdata;
					end
					if (state_q == S_SCAN1) begin
						rk_q   <= k_q;
						pend_q <= 1'b1;
						if (32'(k_q) == 32'(starts_q) - 32'd1) begin
							state_q <= S_SCAN1T;
						end else begin
							k_q <= k_q + FW'(1);
						end
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_WIN;
					end
				end
				S_WIN: begin
					lo_q    <= FCW'(lo_w);
					hi_q    <= FCW'(hi_w);
					k_q     <= '0;
					found_q <= 1'b0;
					state_q <= S_SCAN2;
				end
				S_SCAN2, S_SCAN2T: begin
					if (pend_q && !excl && (!found_q || (srdata < sec_val_q))) begin
						sec_val_q <= srdata;
						found_q   <= 1'b1;
					end
					if (state_q == S_SCAN2) begin
						rk_q   <= k_q;
						pend_q <= 1'b1;
						if (32'(k_q) == 32'(starts_q) - 32'd1) begin
							state_q <= S_SCAN2T;
						end else begin
							k_q <= k_q + FW'(1);
						end
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					match_frame_q <= 8'(32'(best_idx_q) + 32'(half_q));
					invalid_q     <= 1'b0;
					rem_q         <= {1'b0, best_val_q};
					dcnt_q        <= '0;
					if (!found_q) begin
						score_ratio_q <= '0;
						done_q        <= 1'b1;
						state_q       <= S_IDLE;
					end else if (best_val_q == sec_val_q) begin
						score_ratio_q <= RATIO_ONE;
						done_q        <= 1'b1;
						state_q       <= S_IDLE;
					end else begin
						state_q <= S_DIVR;
					end
				end
				S_DIVR: begin
					if (trial_r >= {1'b0, sec_val_q}) begin
						rem_q <= trial_r - {1'b0, sec_val_q};
						quo_q <= {quo_q[14:0], 1'b1};
					end else begin
						rem_q <= trial_r;
						quo_q <= {quo_q[14:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 4'd1;
					if (dcnt_q == 4'd15) begin
						score_ratio_q <= {1'b0, quo_q[14:0],
							(trial_r >= {1'b0, sec_val_q})};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/stm_ram.sv =====
// ----------------------------------------------------------------------------
// stm_ram
// Simple dual port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module stm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/stm_checker.sv =====
// ----------------------------------------------------------------------------
// stm_checker
// Port level checks of the sequence trajectory matcher.
// ----------------------------------------------------------------------------
module stm_checker
	import stm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        opcode,
	input logic        done,
	input logic [7:0]  match_frame,
	input logic [16:0] score_ratio,
	input logic        invalid
);

	// a result only shows once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && invalid) |-> (match_frame == 8'd0 && score_ratio == 17'd0))
		else $error("invalid result carries data");

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (score_ratio <= RATIO_ONE)) else $error("ratio above one");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !opcode) |=> !done) else $error("load gave a result");

	a_query_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("query ended without result");

endmodule

bind sequence_trajectory_matcher stm_checker u_stm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.opcode      (opcode),
	.done        (done),
	.match_frame (match_frame),
	.score_ratio (score_ratio),
	.invalid     (invalid)
);

// ===== sim/sequence_trajectory_matcher_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequence_trajectory_matcher_tb
// Self-checking bench for the sequence trajectory matcher.
// ----------------------------------------------------------------------------
// Every cell that a query can read is loaded first. A directed table runs
// under the reset defaults, then random loads and queries under several
// settings. Each result is checked field by field against the table or model.
// ----------------------------------------------------------------------------
module sequence_trajectory_matcher_tb;
	import stm_pkg::*;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam int   STALL_LIMIT = 10000;

	typedef struct packed {
		logic [7:0]  frame;
		logic [16:0] ratio;
		logic        inv;
	} match_t;

	typedef struct {
		logic        op;
		logic [7:0]  row;
		logic [7:0]  col;
		logic [15:0] value;
		logic [7:0]  frame;
		bit          typed;
		match_t      want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        opcode;
	logic [7:0]  row_index;
	logic [7:0]  col_index;
	logic [15:0] diff_value;
	logic [7:0]  query_frame;
	logic        done;
	logic [7:0]  match_frame;
	logic [16:0] score_ratio;
	logic        invalid;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [8:0]  cfg_data;

	sequence_trajectory_matcher dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .row_index(row_index), .col_index(col_index),
		.diff_value(diff_value), .query_frame(query_frame), .done(done),
		.match_frame(match_frame), .score_ratio(score_ratio), .invalid(invalid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [15:0] cells [0:65535];
	bit          loaded [0:65535];
	logic [8:0]  frames_reg;
	logic [6:0]  len_reg;
	logic [7:0]  shift_lo_reg;
	logic [7:0]  shift_hi_reg;
	logic [8:0]  window_reg;
	int unsigned scores [0:255];

	match_t pending_matches[$];
	int     mismatches;
	int     idle_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned eff_frames();
		if (frames_reg < 2) return 2;
		if (frames_reg > 256) return 256;
		return frames_reg;
	endfunction

	function automatic int unsigned eff_len();
		int unsigned m;
		m = len_reg + (len_reg & 1);
		if (m < 2) m = 2;
		if (m > 64) m = 64;
		return m;
	endfunction

	function automatic match_t predict_match(input logic [7:0] n);
		int unsigned f, m, half, nstarts, row0, vtop, lo, hi, half_r;
		int unsigned sum, low, col, best, second;
		bit          found;
		longint unsigned ratio;
		match_t r;
		f = eff_frames();
		m = eff_len();
		half = m / 2;
		r = '0;
		if (f < m + 2 || n < half + 1 || n > f - half - 1) begin
			r.inv = 1'b1;
			return r;
		end
		nstarts = f - m;
		row0 = n - half - 1;
		vtop = (shift_hi_reg < shift_lo_reg) ? shift_lo_reg : shift_hi_reg;
		for (int unsigned s = 0; s < nstarts; s++) begin
			low = 32'hFFFF_FFFF;
			for (int unsigned v = shift_lo_reg; v <= vtop; v++) begin
				sum = 0;
				for (int unsigned i = 0; i <= m; i++) begin
					col = s + (i * v) / m;
					if (col > f - 1) col = f - 1;
					sum += cells[(row0 + i) * 256 + col];
				end
				if (sum < low) low = sum;
			end
			scores[s] = low;
		end
		best = 0;
		for (int unsigned s = 1; s < nstarts; s++)
			if (scores[s] < scores[best]) best = s;
		half_r = window_reg / 2;
		lo = (best > half_r) ? best - half_r : 0;
		hi = best + half_r;
		if (hi > nstarts) hi = nstarts;
		if (half_r == 0) hi = lo;
		found = 0;
		second = 0;
		for (int unsigned k = 0; k < nstarts; k++) begin
			if (k >= lo && k < hi) continue;
			if (!found || scores[k] < scores[second]) begin
				second = k;
				found = 1;
			end
		end
		if (!found) ratio = 0;
		else if (scores[second] == 0) ratio = RATIO_ONE;
		else begin
			ratio = (longint'(scores[best]) << 16) / scores[second];
			if (ratio > RATIO_ONE) ratio = RATIO_ONE;
		end
		r.frame = 8'((best + half) & 8'hFF);
		r.ratio = ratio[16:0];
		return r;
	endfunction

	function automatic logic [15:0] rand_diff();
		case ($urandom_range(0, 7))
			0, 1: return 16'h0000;
			2: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic idle_gap();
		int unsigned n;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: n = 0;
			4, 5, 6, 7: n = $urandom_range(1, 3);
			8: n = $urandom_range(4, 12);
			default: n = $urandom_range(20, 60);
		endcase
		repeat (n) @(negedge clk);
	endtask

	// drives one item from the falling edge; returns after its transfer
	task automatic issue(input logic op, input logic [7:0] r, input logic [7:0] c,
			input logic [15:0] v, input logic [7:0] n, input bit typed,
			input match_t want);
		start = 1'b1;
		opcode = op;
		row_index = r;
		col_index = c;
		diff_value = v;
		query_frame = n;
		do @(posedge clk); while (busy);
		if (op == OP_LOAD) begin
			cells[{r, c}] = v;
			loaded[{r, c}] = 1;
		end else if (typed) pending_matches = {pending_matches, want};
		else pending_matches = {pending_matches, predict_match(n)};
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic send(input logic op, input logic [7:0] r, input logic [7:0] c,
			input logic [15:0] v, input logic [7:0] n, input bit gaps);
		if (gaps) idle_gap();
		issue(op, r, c, v, n, 0, '0);
	endtask

	task automatic drain();
		while (pending_matches.size() != 0 || busy) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [8:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FRAME_COUNT:   frames_reg = data;
			CFG_MATCH_LEN:     len_reg = data[6:0];
			CFG_MIN_SHIFT:     shift_lo_reg = data[7:0];
			CFG_MAX_SHIFT:     shift_hi_reg = data[7:0];
			CFG_REJECT_WINDOW: window_reg = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_regs(input logic [8:0] f, input logic [6:0] m,
			input logic [7:0] lo, input logic [7:0] hi, input logic [8:0] w);
		drain();
		reg_write(CFG_FRAME_COUNT, f);
		reg_write(CFG_MATCH_LEN, {2'b0, m});
		reg_write(CFG_MIN_SHIFT, {1'b0, lo});
		reg_write(CFG_MAX_SHIFT, {1'b0, hi});
		reg_write(CFG_REJECT_WINDOW, w);
	endtask

	// loads every cell that a query under the current size can read
	task automatic fill_matrix();
		int unsigned f;
		f = eff_frames();
		for (int unsigned r = 0; r < f; r++)
			for (int unsigned c = 0; c < f; c++)
				if (!loaded[r * 256 + c])
					send(OP_LOAD, 8'(r), 8'(c), rand_diff(), 8'($urandom), 0);
	endtask

	task automatic random_items(input int unsigned count, input int unsigned max_queries);
		int unsigned f, half, q;
		logic [7:0]  n;
		f = eff_frames();
		half = eff_len() / 2;
		q = 0;
		for (int unsigned k = 0; k < count; k++) begin
			if (q < max_queries && $urandom_range(0, 1)) begin
				if ($urandom_range(0, 3) != 0 && f >= 2 * half + 2)
					n = 8'($urandom_range(half + 1, f - half - 1));
				else n = 8'($urandom);
				send(OP_QUERY, 8'($urandom), 8'($urandom), 16'($urandom), n, 1);
				q++;
			end else if ($urandom_range(0, 1))
				send(OP_LOAD, 8'($urandom_range(0, f - 1)), 8'($urandom_range(0, f - 1)),
					rand_diff(), 8'($urandom), 1);
			else
				send(OP_LOAD, 8'($urandom), 8'($urandom), rand_diff(), 8'($urandom), 1);
		end
	endtask

	stim_row_t table_rows[$];

	initial begin
		stim_row_t t;
		match_t    bad;
		start = 1'b0;
		opcode = OP_LOAD;
		row_index = '0;
		col_index = '0;
		diff_value = '0;
		query_frame = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		frames_reg = 9'd256;
		len_reg = 7'd10;
		shift_lo_reg = 8'd8;
		shift_hi_reg = 8'd12;
		window_reg = 9'd20;
		for (int i = 0; i < 65536; i++) begin
			cells[i] = '0;
			loaded[i] = 0;
		end
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		bad = '0;
		bad.inv = 1'b1;
		t = '{OP_LOAD, 8'd0, 8'd0, 16'h0000, 8'd0, 0, '0};         table_rows = {table_rows, t};
		t = '{OP_LOAD, 8'd255, 8'd255, 16'hFFFF, 8'd255, 0, '0};   table_rows = {table_rows, t};
		t = '{OP_LOAD, 8'd0, 8'd255, 16'hFFFF, 8'd0, 0, '0};       table_rows = {table_rows, t};
		t = '{OP_LOAD, 8'd255, 8'd0, 16'h0001, 8'd0, 0, '0};       table_rows = {table_rows, t};
		t = '{OP_QUERY, 8'd0, 8'd0, 16'h0, 8'd0, 1, bad};          table_rows = {table_rows, t};
		t = '{OP_QUERY, 8'd255, 8'd255, 16'hFFFF, 8'd255, 1, bad}; table_rows = {table_rows, t};
		t = '{OP_QUERY, 8'd0, 8'd0, 16'h0, 8'd5, 1, bad};          table_rows = {table_rows, t};
		t = '{OP_QUERY, 8'd0, 8'd0, 16'h0, 8'd251, 1, bad};        table_rows = {table_rows, t};

		// corner loads and out-of-range queries under the reset defaults
		foreach (table_rows[i]) begin
			idle_gap();
			issue(table_rows[i].op, table_rows[i].row, table_rows[i].col,
				table_rows[i].value, table_rows[i].frame, table_rows[i].typed,
				table_rows[i].want);
		end

		// every query invalid: sizes clamp up and down
		set_regs(9'd0, 7'd127, 8'd0, 8'd255, 9'd511);
		random_items(8, 4);
		// shortest trajectory, one shift of zero, window off
		set_regs(9'd8, 7'd2, 8'd0, 8'd0, 9'd0);
		fill_matrix();
		random_items(8, 4);
		// odd length, max below min, window of one
		set_regs(9'd8, 7'd3, 8'd5, 8'd2, 9'd1);
		random_items(8, 4);
		// window covers every start
		set_regs(9'd8, 7'd6, 8'd0, 8'd12, 9'd256);
		random_items(8, 4);
		// steep shift of 128, columns clamp at the edge
		set_regs(9'd8, 7'd6, 8'd128, 8'd128, 9'd2);
		random_items(8, 4);
		// many shifts, window wider than the starts
		set_regs(9'd8, 7'd2, 8'd0, 8'd12, 9'd20);
		random_items(8, 4);

		drain();
		if (mismatches == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		match_t got;
		match_t want;
		if (arst_n && done) begin
			got = '{match_frame, score_ratio, invalid};
			if (pending_matches.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result frame=%0d ratio=%0d invalid=%0b",
						match_frame, score_ratio, invalid);
			end else begin
				want = pending_matches.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0d/%0b, got %0d/%0d/%0b",
							want.frame, want.ratio, want.inv,
							got.frame, got.ratio, got.inv);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else idle_cycles <= idle_cycles + 1;
	end

endmodule
